### rtl/core/fsd_pkg.sv
package fsd_pkg;

    localparam int GREY_W       = 8;
    localparam int ERR_W        = 8;
    localparam int COLUMN_OUT_W = 7;
    localparam int ROW_OUT_W    = 6;

    localparam logic [GREY_W-1:0] THRESHOLD_RESET = 8'd128;
    localparam logic [GREY_W-1:0] GREY_MAX        = 8'hFF;

    typedef struct packed {
        logic [GREY_W-1:0] grey_level;
        logic              frame_start;
    } in_word_t;

    typedef struct packed {
        logic                    pixel_on;
        logic [COLUMN_OUT_W-1:0] column;
        logic [ROW_OUT_W-1:0]    row;
        logic                    frame_end;
    } out_word_t;

    // Signed divide by 16 that truncates toward zero.
    function automatic logic signed [11:0] div16(input logic signed [11:0] x);
        logic signed [11:0] biased;
        biased = x + (x[11] ? 12'sd15 : 12'sd0);
        return biased >>> 4;
    endfunction

    // Saturate a 9-bit signed sum to the 8-bit signed error range.
    function automatic logic signed [ERR_W-1:0] sat8(input logic signed [8:0] x);
        logic signed [ERR_W-1:0] result;
        if (x > 9'sd127)
        begin
            result = 8'sd127;
        end
        else if (x < -9'sd128)
        begin
            result = -8'sd128;
        end
        else
        begin
            result = x[7:0];
        end
        return result;
    endfunction

endpackage

### rtl/core/fsd_line_ram.sv
module fsd_line_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read of the address being written returns the new data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (we && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/floyd_steinberg_dither_top.sv
// Floyd-Steinberg ditherer: takes one 8-bit grey pixel per word in raster order
// (LINE_WIDTH pixels per row, FRAME_HEIGHT rows per frame) and returns one word
// per pixel with the on/off bit, its column and row, and a frame_end flag on the
// last pixel of the frame. A pixel marked frame_start begins a new frame at row 0,
// column 0 with all diffused error cleared; after the last pixel of a frame the
// position wraps and the error is cleared the same way. The block takes a new word
// every clock while the output side is not stalled. Each accepted pixel is
// registered with its line memory entry, and its error arithmetic is then
// registered into the output register once the output side is not stalled.
// The error lines live in a single two-bank memory of 2 * 2**clog2(LINE_WIDTH)
// signed 8-bit entries with one read and one write port; no clearing pass is
// needed after reset because row 0 ignores what it reads from the memory and
// every row rewrites each entry that the next row reads from the memory.
// The threshold register (reset value 128) is written through cfg_we/cfg_data
// and must only be changed while no pixel is in flight.
module floyd_steinberg_dither_top #(
    parameter int LINE_WIDTH   = 128,
    parameter int FRAME_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  fsd_pkg::in_word_t in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output fsd_pkg::out_word_t out_word,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data
);

    import fsd_pkg::*;

    localparam int COL_W  = $clog2(LINE_WIDTH);
    localparam int ROW_W  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int ADDR_W = COL_W + 1;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_WIDTH - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_HEIGHT - 1);

    // Pixel held in the arithmetic stage while its line entry is read.
    typedef struct packed {
        logic [GREY_W-1:0] grey;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              first_col;
        logic              first_row;
        logic              last_col;
        logic              frame_end;
    } stage_t;

    // ------------------------------------------------------------------
    // Handshake and registers
    // ------------------------------------------------------------------
    logic [GREY_W-1:0] threshold_reg, threshold_next;
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;

    logic   s1_valid_reg, s1_valid_next;
    stage_t s1_reg, s1_next;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;

    // Running error for the pixel to the right and the two partial sums of the
    // next line entries that still wait for contributions.
    logic signed [ERR_W-1:0] right_err_reg, right_err_next;
    logic signed [ERR_W-1:0] part_prev_reg, part_prev_next;
    logic signed [ERR_W-1:0] part_cur_reg, part_cur_next;

    // The last entry of a row is written in the cycle after its pixel, when the port is free.
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ERR_W-1:0]  pend_data_reg, pend_data_next;

    logic accept;
    logic advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // ------------------------------------------------------------------
    // Position tracking at the input side
    // ------------------------------------------------------------------
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] pos_row;
    logic             pos_last_col;
    logic             pos_last_row;

    always_comb
    begin
        pos_col      = in_word.frame_start ? '0 : col_cnt_reg;
        pos_row      = in_word.frame_start ? '0 : row_cnt_reg;
        pos_last_col = (pos_col == LAST_COL);
        pos_last_row = (pos_row == LAST_ROW);

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        s1_next      = s1_reg;
        if (accept)
        begin
            if (pos_last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = pos_last_row ? '0 : pos_row + ROW_W'(1);
            end
            else
            begin
                col_cnt_next = pos_col + COL_W'(1);
                row_cnt_next = pos_row;
            end
            s1_next.grey      = in_word.grey_level;
            s1_next.col       = pos_col;
            s1_next.row       = pos_row;
            s1_next.first_col = (pos_col == '0);
            s1_next.first_row = (pos_row == '0);
            s1_next.last_col  = pos_last_col;
            s1_next.frame_end = pos_last_col && pos_last_row;
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        threshold_next = cfg_we ? cfg_data : threshold_reg;
    end

    // ------------------------------------------------------------------
    // Line memory: bank row[0] holds the errors read by row, the other bank
    // gathers the errors for the following row.
    // ------------------------------------------------------------------
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_wr_addr;
    logic [ERR_W-1:0]        ram_wr_data;
    logic [ERR_W-1:0]        ram_rd_data;
    logic                    reg_we;
    logic signed [ERR_W-1:0] below_left_val;

    fsd_line_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (ERR_W)
    ) u_line_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr ({pos_row[0], pos_col}),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Error arithmetic
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0] cur_eff;
    logic signed [ERR_W-1:0] right_eff;
    logic signed [ERR_W-1:0] prev_eff;
    logic signed [ERR_W-1:0] pcur_eff;
    logic signed [9:0]       adj_wide;
    logic [GREY_W-1:0]       adj;
    logic                    on;
    logic signed [8:0]       qerr;
    logic signed [11:0]      q_ext;
    logic signed [11:0]      share7;
    logic signed [11:0]      share5;
    logic signed [11:0]      share3;
    logic signed [11:0]      share1;
    logic signed [8:0]       below_left_sum;

    always_comb
    begin
        // Row 0 sees a cleared line; column 0 starts with no carried error.
        cur_eff   = s1_reg.first_row ? '0 : $signed(ram_rd_data);
        right_eff = s1_reg.first_col ? '0 : right_err_reg;
        prev_eff  = s1_reg.first_col ? '0 : part_prev_reg;
        pcur_eff  = s1_reg.first_col ? '0 : part_cur_reg;

        adj_wide = $signed({2'b00, s1_reg.grey})
                 + {{2{cur_eff[ERR_W-1]}}, cur_eff}
                 + {{2{right_eff[ERR_W-1]}}, right_eff};
        if (adj_wide[9])
        begin
            adj = '0;
        end
        else if (adj_wide[8])
        begin
            adj = GREY_MAX;
        end
        else
        begin
            adj = adj_wide[7:0];
        end

        on   = (adj >= threshold_reg);
        qerr = on ? $signed({1'b0, adj}) - $signed({1'b0, GREY_MAX})
                  : $signed({1'b0, adj});

        q_ext  = {{3{qerr[8]}}, qerr};
        share7 = div16(q_ext * 12'sd7);
        share5 = div16(q_ext * 12'sd5);
        share3 = div16(q_ext * 12'sd3);
        share1 = div16(q_ext);

        // Entry below-left is complete once this pixel adds its share.
        below_left_sum = {prev_eff[ERR_W-1], prev_eff} + share3[8:0];
        below_left_val = sat8(below_left_sum);

        part_prev_next = pcur_eff + share5[7:0];
        part_cur_next  = share1[7:0];
        right_err_next = s1_reg.last_col ? '0 : share7[7:0];

        out_word_next.pixel_on  = on;
        out_word_next.column    = COLUMN_OUT_W'(s1_reg.col);
        out_word_next.row       = ROW_OUT_W'(s1_reg.row);
        out_word_next.frame_end = s1_reg.frame_end;

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        reg_we = advance && !s1_reg.first_col;

        pend_valid_next = advance && s1_reg.last_col;
        pend_addr_next  = {~s1_reg.row[0], s1_reg.col};
        pend_data_next  = part_prev_next;

        // The pending write falls in a cycle in which the stage holds a column 0 pixel or none.
        ram_we = reg_we || pend_valid_reg;
        if (pend_valid_reg)
        begin
            ram_wr_addr = pend_addr_reg;
            ram_wr_data = pend_data_reg;
        end
        else
        begin
            ram_wr_addr = {~s1_reg.row[0], s1_reg.col - COL_W'(1)};
            ram_wr_data = below_left_val;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            threshold_reg  <= threshold_next;
            col_cnt_reg    <= col_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        if (advance)
        begin
            out_word_reg  <= out_word_next;
            right_err_reg <= right_err_next;
            part_prev_reg <= part_prev_next;
            part_cur_reg  <= part_cur_next;
            pend_addr_reg <= pend_addr_next;
            pend_data_reg <= pend_data_next;
        end
    end

endmodule
